[rtl/core/assert_macros.svh]
// assertion macros shared by the reducer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/teru_pkg.sv]
// types, codes and helper functions of the tensor element reducer
// no dependencies; used by every .sv rtl file of the block
package teru_pkg;

  localparam int VALUE_W     = 32;
  localparam int OFFSET_W    = 32;
  localparam int ACC_W       = 64;
  localparam int MODE_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM     = 3'd0,
    MODE_SUM_ABS = 3'd1,
    MODE_MAX     = 3'd2,
    MODE_MAX_ABS = 3'd3,
    MODE_MIN     = 3'd4,
    MODE_MIN_ABS = 3'd5,
    MODE_NORM    = 3'd6
  } mode_t;

  // one classified element as it sits in the queue
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;      // sign-extended element
    logic [VALUE_W-1:0]        magnitude;  // saturated absolute value
    logic [ACC_W-1:0]          square;     // magnitude squared
    logic [OFFSET_W-1:0]       offset;
    logic                      last;
  } elem_t;

  function automatic logic [ACC_W-1:0] init_value(input logic [MODE_W-1:0] m);
    logic [ACC_W-1:0] r;
    case (m)
      MODE_MAX, MODE_MAX_ABS: r = {1'b1, {(ACC_W-1){1'b0}}};
      MODE_MIN, MODE_MIN_ABS: r = {1'b0, {(ACC_W-1){1'b1}}};
      default:                r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] add_sat(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = b[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

[rtl/core/teru_streams.sv]
// stream interfaces for elements in and results out
// depends on teru_pkg for field widths
interface element_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [teru_pkg::VALUE_W-1:0]  element_value;
  logic [teru_pkg::OFFSET_W-1:0]        element_offset;
  logic                                 last;

  modport source(output valid, element_value, element_offset, last, input ready);
  modport sink(input valid, element_value, element_offset, last, output ready);
endinterface

interface result_if;
  logic                               valid;
  logic                               ready;
  logic signed [teru_pkg::ACC_W-1:0]  result_value;
  logic [teru_pkg::OFFSET_W-1:0]      result_index;

  modport source(output valid, result_value, result_index, input ready);
  modport sink(input valid, result_value, result_index, output ready);
endinterface

[rtl/core/teru_front.sv]
// front end: accepts elements, sign-extends, takes saturated abs and square
// depends on teru_pkg and element_if; feeds teru_queue
module teru_front #(
  parameter int VALUE_BITS = 32
) (
  element_if.sink         element,
  input  logic            q_full,
  output logic            push,
  output teru_pkg::elem_t push_data
);
  import teru_pkg::*;

  logic signed [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0]        neg;
  logic [VALUE_BITS-1:0]        mag;

  assign element.ready = !q_full;
  assign push          = element.valid && !q_full;

  always_comb begin
    v   = element.element_value[VALUE_BITS-1:0];
    neg = -v;
    // abs of the most negative value saturates to the largest positive
    if (!v[VALUE_BITS-1]) begin
      mag = v;
    end else if (neg[VALUE_BITS-1]) begin
      mag = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else begin
      mag = neg;
    end
    push_data.value     = VALUE_W'(v);
    push_data.magnitude = VALUE_W'(mag);
    push_data.square    = ACC_W'(push_data.magnitude) * ACC_W'(push_data.magnitude);
    push_data.offset    = element.element_offset;
    push_data.last      = element.last;
  end

endmodule

[rtl/core/teru_queue.sv]
// short fifo of classified elements between front and back end
// depends on teru_pkg and assert_macros.svh
`include "assert_macros.svh"
module teru_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  teru_pkg::elem_t push_data,
  output logic            full,
  output logic            head_valid,
  output teru_pkg::elem_t head,
  input  logic            pop
);
  import teru_pkg::*;

  elem_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full, "push into full queue")
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, count != '0, "pop from empty queue")

endmodule

[rtl/core/teru_back.sv]
// back end: mode register, accumulator, square root unit and result register
// depends on teru_pkg, result_if and assert_macros.svh; drains teru_queue
`include "assert_macros.svh"
module teru_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [teru_pkg::MODE_W-1:0]   cfg_data,
  input  logic                          head_valid,
  input  teru_pkg::elem_t               head,
  output logic                          pop,
  result_if.source                      result
);
  import teru_pkg::*;

  logic [MODE_W-1:0]          mode;
  logic [ACC_W-1:0]           running;
  logic [OFFSET_W-1:0]        best;
  logic [ACC_W-1:0]           root_x;
  logic [ACC_W-1:0]           root_res;
  logic [ACC_W-1:0]           root_bit;
  logic                       root_pend;
  logic                       out_valid;
  logic signed [ACC_W-1:0]    out_value;
  logic [OFFSET_W-1:0]        out_index;

  logic                       root_active;
  logic                       out_free;
  logic signed [ACC_W-1:0]    v64;
  logic signed [ACC_W-1:0]    a64;
  logic signed [ACC_W-1:0]    cur;
  logic [ACC_W:0]             usum;
  logic [ACC_W-1:0]           running_next;
  logic [OFFSET_W-1:0]        best_next;
  logic                       is_extreme;
  logic [ACC_W-1:0]           trial;

  assign root_active = (root_bit != '0);
  assign out_free    = !out_valid || result.ready;
  assign pop         = head_valid && !root_active && !root_pend && (!head.last || out_free);
  assign is_extreme  = (mode == MODE_MAX) || (mode == MODE_MAX_ABS) ||
                       (mode == MODE_MIN) || (mode == MODE_MIN_ABS);
  assign trial       = root_res + root_bit;

  assign result.valid        = out_valid;
  assign result.result_value = out_value;
  assign result.result_index = out_index;

  always_comb begin
    v64          = ACC_W'(head.value);
    a64          = $signed({{(ACC_W-VALUE_W){1'b0}}, head.magnitude});
    cur          = running;
    usum         = {1'b0, running} + {1'b0, head.square};
    running_next = running;
    best_next    = best;
    case (mode)
      MODE_SUM_ABS: running_next = add_sat(cur, a64);
      MODE_MAX: begin
        if (v64 > cur) begin
          running_next = v64;
          best_next    = head.offset;
        end
      end
      MODE_MAX_ABS: begin
        if (a64 > cur) begin
          running_next = a64;
          best_next    = head.offset;
        end
      end
      MODE_MIN: begin
        if (v64 < cur) begin
          running_next = v64;
          best_next    = head.offset;
        end
      end
      MODE_MIN_ABS: begin
        if (a64 < cur) begin
          running_next = a64;
          best_next    = head.offset;
        end
      end
      // sum of squares sticks at all ones
      MODE_NORM: running_next = usum[ACC_W] ? '1 : usum[ACC_W-1:0];
      default: running_next = add_sat(cur, v64);
    endcase
  end

  // accumulator and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_SUM;
      running <= '0;
      best    <= '0;
    end else if (cfg_write) begin
      mode    <= cfg_data;
      running <= init_value(cfg_data);
      best    <= '0;
    end else if (pop) begin
      if (head.last) begin
        running <= init_value(mode);
        best    <= '0;
      end else begin
        running <= running_next;
        best    <= best_next;
      end
    end
  end

  // square root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      root_bit  <= '0;
      root_pend <= 1'b0;
    end else begin
      if (pop && head.last && (mode == MODE_NORM)) begin
        root_bit <= {2'b01, {(ACC_W-2){1'b0}}};
      end else if (root_active) begin
        root_bit <= root_bit >> 2;
      end
      if (root_active && (root_bit == ACC_W'(1))) begin
        root_pend <= 1'b1;
      end else if (root_pend && out_free) begin
        root_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last && (mode == MODE_NORM)) begin
      root_x   <= running_next;
      root_res <= '0;
    end else if (root_active) begin
      if (root_x >= trial) begin
        root_x   <= root_x - trial;
        root_res <= (root_res >> 1) + root_bit;
      end else begin
        root_res <= root_res >> 1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (root_pend && out_free) begin
      out_valid <= 1'b1;
    end else if (pop && head.last && (mode != MODE_NORM)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (root_pend && out_free) begin
      out_value <= root_res;
      out_index <= '0;
    end else if (pop && head.last && (mode != MODE_NORM)) begin
      out_value <= running_next;
      out_index <= is_extreme ? best_next : '0;
    end
  end

  `ASSERT_NEXT(a_root_finish, clk, rst, root_active && (root_bit == ACC_W'(1)), root_pend,
               "square root finished without pending result")
  `ASSERT_IMPLIES(a_root_exclusive, clk, rst, root_pend, !root_active,
                  "square root running while result pending")

endmodule

[rtl/core/tensor_element_reducer_unit.sv]
// top level of the tensor element reducer
// depends on teru_pkg, teru_streams, teru_front, teru_queue, teru_back
//
// Reduces a stream of signed fixed-point elements to one result per element
// marked last: sum, sum of abs, max, max-abs, min, min-abs (with the offset of
// the first extreme element) or Euclidean norm. Elements are taken one per
// cycle into a four-entry queue unless full; the back end, when not stalled,
// drains one per cycle. In norm mode the last element starts a 64-bit integer
// square root, one result bit per cycle, during which the queue is not drained
// and fills after four more elements. The user must write the mode register
// through cfg_write/cfg_data only while no reduction is in flight (not
// enforced by the block); a write restarts the running value for the new mode.
module tensor_element_reducer_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [teru_pkg::MODE_W-1:0]  cfg_data,
  element_if.sink                      element,
  result_if.source                     result
);
  import teru_pkg::*;

  logic  q_full;
  logic  push;
  elem_t push_data;
  logic  head_valid;
  elem_t head;
  logic  pop;

  teru_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .element   (element),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  teru_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  teru_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule

[bench/tb.sv]
// self-checking bench for tensor_element_reducer_unit: random and directed element streams
// uses teru_pkg for mode codes and the element_if/result_if stream interfaces of the rtl
// expected reductions are computed on each element transfer and checked in order

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import teru_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;  // undefined code, reduces like sum
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned ELEMENT_TARGET = 1050;
  localparam int unsigned SETTLE_CYCLES = 64;   // covers queue drain, the square root and a margin
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned TAIL_ELEMENTS = 120;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned TIMEOUT_NS = 1_000_000;

  typedef enum logic {STEP_ELEMENT, STEP_MODE_WRITE} step_kind_e;

  typedef struct {
    step_kind_e        kind;
    logic [31:0]       value;
    logic [31:0]       offset;
    logic              last;
    logic [MODE_W-1:0] mode;
  } plan_step_t;

  typedef struct {
    logic signed [63:0] value;
    logic [31:0]        index;
  } reduction_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic [MODE_W-1:0] cfg_data;

  element_if elem_ch();
  result_if  res_ch();

  tensor_element_reducer_unit #(
    .VALUE_BITS(32)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .element(elem_ch),
    .result(res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  plan_step_t  element_plan[$];
  reduction_t  expected_reductions[$];
  int unsigned planned_elements = 0;
  int unsigned elements_taken = 0;
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  logic        elem_fire = 1'b0;
  logic        tail_phase = 1'b0;
  logic [31:0] prev_value = '0;

  // predictor state
  logic [MODE_W-1:0]  cur_mode;
  logic signed [63:0] acc;
  logic [31:0]        best_off;

  function automatic logic signed [63:0] start_value(logic [MODE_W-1:0] m);
    case (m)
      MODE_MAX, MODE_MAX_ABS: return ACC_MIN;
      MODE_MIN, MODE_MIN_ABS: return ACC_MAX;
      default:                return '0;
    endcase
  endfunction

  function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] wide;
    wide = {a[63], a} + {b[63], b};
    if (wide[64] != wide[63]) return wide[64] ? ACC_MIN : ACC_MAX;
    return wide[63:0];
  endfunction

  function automatic logic signed [63:0] magnitude_of(logic signed [63:0] v);
    if (v >= 0) return v;
    if (v == -64'sd2147483648) return 64'sd2147483647;
    return -v;
  endfunction

  // floor square root, one result bit at a time from the top
  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if ({32'd0, t} * {32'd0, t} <= x) r = t;
    end
    return {32'd0, r};
  endfunction

  task automatic set_mode(logic [MODE_W-1:0] m);
    cur_mode = m;
    acc = start_value(m);
    best_off = '0;
  endtask

  task automatic reduce_element(logic [31:0] raw, logic [31:0] off, logic last);
    logic signed [63:0] v;
    logic signed [63:0] a;
    logic [64:0]        sq_sum;
    reduction_t         r;
    v = {{32{raw[31]}}, raw};
    a = magnitude_of(v);
    case (cur_mode)
      MODE_SUM_ABS: acc = clamp_add(acc, a);
      MODE_MAX:     if (v > acc) begin acc = v; best_off = off; end
      MODE_MAX_ABS: if (a > acc) begin acc = a; best_off = off; end
      MODE_MIN:     if (v < acc) begin acc = v; best_off = off; end
      MODE_MIN_ABS: if (a < acc) begin acc = a; best_off = off; end
      MODE_NORM: begin
        // unsigned sum of squares, sticks at all ones
        sq_sum = {1'b0, acc} + {1'b0, a * a};
        acc = sq_sum[64] ? '1 : sq_sum[63:0];
      end
      default: acc = clamp_add(acc, v);
    endcase
    if (last) begin
      r.value = (cur_mode == MODE_NORM) ? floor_root(acc) : acc;
      r.index = (cur_mode >= MODE_MAX && cur_mode <= MODE_MIN_ABS) ? best_off : '0;
      expected_reductions.push_back(r);
      set_mode(cur_mode);
    end
  endtask

  task automatic plan_mode(logic [MODE_W-1:0] m);
    plan_step_t s;
    s.kind = STEP_MODE_WRITE;
    s.value = '0;
    s.offset = '0;
    s.last = 1'b0;
    s.mode = m;
    element_plan.push_back(s);
  endtask

  task automatic plan_element(logic [31:0] v, logic [31:0] off, logic last);
    plan_step_t s;
    s.kind = STEP_ELEMENT;
    s.value = v;
    s.offset = off;
    s.last = last;
    s.mode = MODE_SUM;
    element_plan.push_back(s);
    planned_elements++;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = MOST_NEG;
      1:       v = MOST_POS;
      2:       v = $urandom_range(0, 64) - 32;
      3:       v = prev_value;  // repeats exercise the strict compare
      4:       v = '0;
      default: v = $urandom;
    endcase
    prev_value = v;
    return v;
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic build_directed();
    plan_mode(MODE_SUM);
    plan_element(MOST_POS, 32'd0, 1'b0);
    plan_element(MOST_NEG, 32'hFFFF_FFFF, 1'b0);
    plan_element(32'hFFFF_FFFF, 32'd1, 1'b1);
    // abs of the most negative element saturates
    plan_mode(MODE_SUM_ABS);
    plan_element(MOST_NEG, 32'd5, 1'b0);
    plan_element(-32'sd3, 32'd6, 1'b1);
    // ties keep the first offset
    plan_mode(MODE_MAX);
    plan_element(32'd5, 32'd10, 1'b0);
    plan_element(32'd5, 32'd11, 1'b0);
    plan_element(MOST_NEG, 32'd12, 1'b1);
    plan_mode(MODE_MAX_ABS);
    plan_element(MOST_NEG, 32'd20, 1'b0);
    plan_element(MOST_POS, 32'd21, 1'b1);
    plan_mode(MODE_MIN);
    plan_element(MOST_NEG, 32'hFFFF_FFFF, 1'b0);
    plan_element(MOST_NEG, 32'd3, 1'b1);
    plan_mode(MODE_MIN_ABS);
    plan_element(32'd0, 32'd7, 1'b0);
    plan_element(32'd0, 32'd8, 1'b1);
    // five full-scale squares overflow the norm sum
    plan_mode(MODE_NORM);
    for (int i = 0; i < 5; i++) plan_element(MOST_NEG, 32'd0, i == 4);
    plan_element(32'd3, 32'd1, 1'b0);
    plan_element(32'd4, 32'd2, 1'b1);
    plan_mode(MODE_UNUSED);
    plan_element(32'd100, 32'd0, 1'b0);
    plan_element(-32'sd50, 32'd0, 1'b1);
    // mode change in the middle of a reduction drops the partial value
    plan_element(32'd9, 32'd0, 1'b0);
    plan_mode(MODE_MAX);
    plan_element(-32'sd9, 32'd4, 1'b1);
  endtask

  task automatic build_random();
    int unsigned groups;
    int unsigned len;
    while (planned_elements < ELEMENT_TARGET) begin
      plan_mode(MODE_W'($urandom_range(0, 7)));
      groups = $urandom_range(1, 6);
      for (int g = 0; g < groups; g++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) plan_element(pick_value(), pick_offset(), k == len - 1);
      end
      // sometimes leave a reduction unfinished before the next mode write
      if (planned_elements + 50 < ELEMENT_TARGET && $urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) plan_element(pick_value(), pick_offset(), 1'b0);
      end
    end
  endtask

  // monitor: predicts on element transfers, checks result transfers
  always @(posedge clk) begin
    reduction_t want;
    logic       busy;
    elem_fire = 1'b0;
    busy = 1'b0;
    if (rst) begin
      set_mode(MODE_SUM);
    end else begin
      if (cfg_write) begin
        set_mode(cfg_data);
        busy = 1'b1;
      end
      if (elem_ch.valid && elem_ch.ready) begin
        elem_fire = 1'b1;
        busy = 1'b1;
        elements_taken++;
        reduce_element(elem_ch.element_value, elem_ch.element_offset, elem_ch.last);
      end
      if (res_ch.valid && res_ch.ready) begin
        busy = 1'b1;
        if (expected_reductions.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: value %h index %h", res_ch.result_value,
                     res_ch.result_index);
        end else begin
          want = expected_reductions.pop_front();
          if (res_ch.result_value !== want.value || res_ch.result_index !== want.index) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("result mismatch: expected value %h index %h, got value %h index %h",
                       want.value, want.index, res_ch.result_value, res_ch.result_index);
          end
        end
      end
      if (busy || expected_reductions.size() != 0) quiet_cycles = 0;
      else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
      tail_phase = elements_taken + TAIL_ELEMENTS >= planned_elements;
    end
  end

  // element driver
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  always @(negedge clk) begin
    plan_step_t step;
    logic       nxt_valid;
    logic       nxt_cfg;
    nxt_cfg = 1'b0;
    if (!rst) begin
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
      if (!elem_ch.valid || elem_fire) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (element_plan.size() != 0) begin
          if (element_plan[0].kind == STEP_MODE_WRITE) begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              step = element_plan.pop_front();
              cfg_data <= step.mode;
              nxt_cfg = 1'b1;
            end
          end else if (!tail_phase && send_calm == 0 && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 6);
          end else begin
            step = element_plan.pop_front();
            elem_ch.element_value <= step.value;
            elem_ch.element_offset <= step.offset;
            elem_ch.last <= step.last;
            nxt_valid = 1'b1;
          end
        end
        elem_ch.valid <= nxt_valid;
      end
    end
    cfg_write <= nxt_cfg;
  end

  // result sink, with one long hold-off to back the block up
  int unsigned take_stall = 0;
  int unsigned take_calm = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  always @(negedge clk) begin
    if (take_calm > 0) take_calm--;
    else if ($urandom_range(0, 39) == 0) take_calm = $urandom_range(20, 60);
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (!hold_done && elements_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      res_ch.ready <= 1'b0;
    end else if (take_stall > 0) begin
      take_stall--;
      res_ch.ready <= 1'b0;
    end else if (!tail_phase && take_calm == 0 && $urandom_range(0, 4) == 0) begin
      take_stall = $urandom_range(0, 6);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  initial begin
    elem_ch.valid = 1'b0;
    elem_ch.element_value = '0;
    elem_ch.element_offset = '0;
    elem_ch.last = 1'b0;
    res_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_data = MODE_SUM;
    build_directed();
    build_random();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (element_plan.size() != 0 || elem_ch.valid || expected_reductions.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_reductions.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", expected_reductions.size());
    end
    if (fail_count == 0)
      $display("tensor_element_reducer_unit verification clean");
    else
      $display("tensor_element_reducer_unit verification failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tensor_element_reducer_unit verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/teru_pkg.sv
rtl/core/teru_streams.sv
rtl/core/teru_front.sv
rtl/core/teru_queue.sv
rtl/core/teru_back.sv
rtl/core/tensor_element_reducer_unit.sv
bench/tb.sv
